FILE: hdl/bcc_pkg.sv
package bcc_pkg;

  // key count and field widths
  localparam int NUM_KEYS = 4;
  localparam int KEY_W    = 4;
  localparam int TS_W     = 32;
  localparam int CFG_W    = 16;
  localparam int CNT_W    = 8;
  localparam int IDX_W    = 1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_LONG_PRESS_TIME     = 1'b0;
  localparam logic [IDX_W-1:0] REG_DOUBLE_CLICK_WINDOW = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST     = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_WINDOW_RST = 16'd500;

  // events raised by one key on one tick
  typedef struct packed {
    logic long_press;
    logic single_click;
    logic double_click;
  } key_evt_t;

endpackage

FILE: hdl/bcc_key.sv
module bcc_key
  import bcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             pressed,
  input  logic [TS_W-1:0]  now,
  input  logic [CFG_W-1:0] long_press_time,
  input  logic [CFG_W-1:0] double_click_window,
  output key_evt_t         evt
);

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_WAITING  = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [TS_W-1:0]   time_r, time_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TS_W-1:0]   elapsed;
  logic              long_hit;
  logic              in_window;

  // modulo 2^32 elapsed time
  assign elapsed   = now - time_r;
  assign long_hit  = elapsed >= {{(TS_W-CFG_W){1'b0}}, long_press_time};
  assign in_window = elapsed <= {{(TS_W-CFG_W){1'b0}}, double_click_window};

  always_comb begin
    phase_nxt = phase_r;
    time_nxt  = time_r;
    count_nxt = count_r;
    evt       = '0;
    case (phase_r)
      PH_RELEASED: begin
        if (pressed) begin
          phase_nxt = PH_PRESSED;
          time_nxt  = now;
        end
      end
      PH_PRESSED: begin
        if (!pressed) begin
          phase_nxt = PH_WAITING;
          time_nxt  = now;
        end else if (long_hit) begin
          phase_nxt      = PH_LONG;
          evt.long_press = 1'b1;
        end
      end
      PH_WAITING: begin
        if (pressed && in_window) begin
          phase_nxt = PH_PRESSED;
          count_nxt = count_r + 1'b1;
        end else if (!in_window) begin
          evt.double_click = (count_r != '0);
          evt.single_click = (count_r == '0);
          count_nxt        = '0;
          phase_nxt        = PH_RELEASED;
        end
      end
      PH_LONG: begin
        // repeat count kept on purpose
        if (!pressed) begin
          phase_nxt = PH_RELEASED;
          time_nxt  = now;
        end
      end
      default: begin
        phase_nxt = PH_RELEASED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASED;
      time_r  <= '0;
      count_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      time_r  <= time_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hdl/button_click_classifier_unit.sv
// Button click classifier. Each input word is one scan tick: a 32-bit
// millisecond timestamp and the pressed level of four keys. Every key runs
// its own released / pressed / waiting / long-press machine and the block
// returns exactly one output word per tick with three event masks (long
// press entered, single click, double click). A word is taken on every clock
// in which in_valid is high and in_stall is low; one word per cycle is
// sustained while out_stall stays low. A word passes through an input
// register, then the per-key update feeding the output register, before its
// result shows on the outputs. The output register lets a new word enter
// while a finished result waits on out_stall. Elapsed time is the wrapping
// difference of timestamps. The user must write the two thresholds through
// cfg_we / cfg_index / cfg_wdata only while the block is idle; the block
// itself does not enforce it. Index 0 is the long press time (reset 1000),
// index 1 the double click window (reset 500).
module button_click_classifier_unit
  import bcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // config write port
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  // tick input
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [TS_W-1:0]  in_timestamp,
  input  logic [KEY_W-1:0] in_key_pressed,
  // event output
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] out_long_press_mask,
  output logic [KEY_W-1:0] out_single_click_mask,
  output logic [KEY_W-1:0] out_double_click_mask
);

  // threshold registers
  logic [CFG_W-1:0] long_press_time_r;
  logic [CFG_W-1:0] double_click_window_r;

  // input stage
  logic             s1_valid_r;
  logic [TS_W-1:0]  s1_time_r;
  logic [KEY_W-1:0] s1_keys_r;

  // output stage
  logic             out_valid_r;
  logic [KEY_W-1:0] lp_mask_r, lp_mask_nxt;
  logic [KEY_W-1:0] sc_mask_r, sc_mask_nxt;
  logic [KEY_W-1:0] dc_mask_r, dc_mask_nxt;

  logic     advance;   // input stage word moves into the output register
  logic     accept;
  key_evt_t evt [NUM_KEYS];

  // output register free or being emptied this cycle
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_time_r     <= LONG_PRESS_TIME_RST;
      double_click_window_r <= DOUBLE_CLICK_WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS_TIME:     long_press_time_r     <= cfg_wdata;
        REG_DOUBLE_CLICK_WINDOW: double_click_window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_time_r <= in_timestamp;
      s1_keys_r <= in_key_pressed;
    end
  end

  // one machine per key, stepped when the tick moves on
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic key_level;
    if (k < KEY_W) begin : g_wired
      assign key_level = s1_keys_r[k];
    end else begin : g_unwired
      // keys past the input field never read as pressed
      assign key_level = 1'b0;
    end

    bcc_key u_key (
      .clk                 (clk),
      .rst_n               (rst_n),
      .step                (advance),
      .pressed             (key_level),
      .now                 (s1_time_r),
      .long_press_time     (long_press_time_r),
      .double_click_window (double_click_window_r),
      .evt                 (evt[k])
    );
  end

  // gather masks, cut to the field width
  always_comb begin
    lp_mask_nxt = '0;
    sc_mask_nxt = '0;
    dc_mask_nxt = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (k < KEY_W) begin
        lp_mask_nxt[k] = evt[k].long_press;
        sc_mask_nxt[k] = evt[k].single_click;
        dc_mask_nxt[k] = evt[k].double_click;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lp_mask_r <= lp_mask_nxt;
      sc_mask_r <= sc_mask_nxt;
      dc_mask_r <= dc_mask_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_long_press_mask   = lp_mask_r;
  assign out_single_click_mask = sc_mask_r;
  assign out_double_click_mask = dc_mask_r;

endmodule

FILE: hdl/bcc_checker.sv
module bcc_checker
  import bcc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [KEY_W-1:0] out_long_press_mask,
  input logic [KEY_W-1:0] out_single_click_mask,
  input logic [KEY_W-1:0] out_double_click_mask
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_long_press_mask)
      && $stable(out_single_click_mask) && $stable(out_double_click_mask))
    else $error("stalled result changed");

  // nothing comes out straight after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty output register never holds back the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a key resolves as single or double, never both
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_single_click_mask & out_double_click_mask) == '0)
    else $error("single and double click on one key");

  // a key entering long press cannot resolve a click in the same tick
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_long_press_mask & (out_single_click_mask | out_double_click_mask)) == '0)
    else $error("long press and click on one key");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (.*);
